// ===== rtl/booth_radix2_multiplier_assert.svh =====
// assertion macros for the booth multiplier top level
// expects clk_i and rst_ni in the scope of each use
`ifndef BOOTH_RADIX2_MULTIPLIER_ASSERT_SVH
`define BOOTH_RADIX2_MULTIPLIER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BR2M_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("booth multiplier check failed");

// antecedent implies consequent in the same cycle
`define BR2M_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("booth multiplier check failed");

`endif

// ===== rtl/br2m_pkg.sv =====
// shared constants and types for the radix-2 booth multiplier
// no dependencies
`timescale 1ns / 1ps

package br2m_pkg;

  localparam int unsigned InBits    = 5;
  localparam int unsigned OutBits   = 9;
  localparam int unsigned WidthDflt = 5;

  // booth recoding of the pair {current bit, previous bit}
  typedef enum logic [1:0] {
    BoothHoldZero = 2'b00,
    BoothAdd      = 2'b01,
    BoothSub      = 2'b10,
    BoothHoldOne  = 2'b11
  } booth_op_e;

endpackage

// ===== rtl/br2m_step.sv =====
// one registered booth add/subtract and arithmetic shift step
// depends on br2m_pkg
`timescale 1ns / 1ps

module br2m_step
  import br2m_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] acc_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic             prev_i,
  input  logic [WIDTH-1:0] mcand_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] acc_o,
  output logic [WIDTH-1:0] q_o,
  output logic             prev_o,
  output logic [WIDTH-1:0] mcand_o
);

  logic             valid_q;
  logic [WIDTH-1:0] acc_d, acc_q;
  logic [WIDTH-1:0] q_d, q_q;
  logic             prev_q;
  logic [WIDTH-1:0] mcand_q;
  logic [WIDTH-1:0] sum;
  booth_op_e        op;

  always_comb begin
    op = booth_op_e'({q_i[0], prev_i});
    unique case (op)
      BoothSub:     sum = acc_i - mcand_i;
      BoothAdd:     sum = acc_i + mcand_i;
      BoothHoldZero,
      BoothHoldOne: sum = acc_i;
      default:      sum = acc_i;
    endcase
    // arithmetic right shift of the acc:q pair
    acc_d = {sum[WIDTH-1], sum[WIDTH-1:1]};
    q_d   = {sum[0], q_i[WIDTH-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    q_q     <= q_d;
    prev_q  <= q_i[0];
    mcand_q <= mcand_i;
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign q_o     = q_q;
  assign prev_o  = prev_q;
  assign mcand_o = mcand_q;

endmodule

// ===== rtl/booth_radix2_multiplier.sv =====
// Signed radix-2 booth multiplier, one booth step per pipeline stage.
// An item is taken in every cycle (busy stays low); its product appears
// on product_o with a one-cycle done_o strobe after passing through
// one operand register stage, then WIDTH step stages, each with its own
// WIDTH-bit adder. The receiver cannot stall, so results are never held
// back and must be captured in the strobe cycle.
// depends on br2m_pkg, br2m_step and booth_radix2_multiplier_assert.svh
`timescale 1ns / 1ps

`include "booth_radix2_multiplier_assert.svh"

module booth_radix2_multiplier
  import br2m_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDflt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [InBits-1:0]  multiplier_i,
  input  logic signed [InBits-1:0]  multiplicand_i,
  output logic                      done_o,
  output logic signed [OutBits-1:0] product_o
);

  localparam int unsigned ProdBits = 2 * WIDTH;
  localparam int unsigned Latency  = WIDTH + 1;

  logic [WIDTH-1:0] mplier_ext, mcand_ext;
  logic             in_valid_q;
  logic [WIDTH-1:0] q_in_q, mcand_in_q;

  logic             valid_s [WIDTH+1];
  logic [WIDTH-1:0] acc_s   [WIDTH+1];
  logic [WIDTH-1:0] q_s     [WIDTH+1];
  logic             prev_s  [WIDTH+1];
  logic [WIDTH-1:0] mcand_s [WIDTH+1];

  logic [ProdBits-1:0] prod_full;

  assign busy = 1'b0;

  // fit operands to the datapath width
  if (WIDTH > InBits) begin : g_ext
    assign mplier_ext = {{(WIDTH-InBits){multiplier_i[InBits-1]}}, multiplier_i};
    assign mcand_ext  = {{(WIDTH-InBits){multiplicand_i[InBits-1]}}, multiplicand_i};
  end else begin : g_cut
    assign mplier_ext = multiplier_i[WIDTH-1:0];
    assign mcand_ext  = multiplicand_i[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    q_in_q     <= mplier_ext;
    mcand_in_q <= mcand_ext;
  end

  assign valid_s[0] = in_valid_q;
  assign acc_s[0]   = '0;
  assign q_s[0]     = q_in_q;
  assign prev_s[0]  = 1'b0;
  assign mcand_s[0] = mcand_in_q;

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    br2m_step #(
      .WIDTH(WIDTH)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .acc_i  (acc_s[i]),
      .q_i    (q_s[i]),
      .prev_i (prev_s[i]),
      .mcand_i(mcand_s[i]),
      .valid_o(valid_s[i+1]),
      .acc_o  (acc_s[i+1]),
      .q_o    (q_s[i+1]),
      .prev_o (prev_s[i+1]),
      .mcand_o(mcand_s[i+1])
    );
  end

  assign prod_full = {acc_s[WIDTH], q_s[WIDTH]};

  if (ProdBits > OutBits) begin : g_prod_cut
    assign product_o = prod_full[OutBits-1:0];
  end else if (ProdBits == OutBits) begin : g_prod_eq
    assign product_o = prod_full;
  end else begin : g_prod_pad
    assign product_o = {{(OutBits-ProdBits){1'b0}}, prod_full};
  end

  assign done_o = valid_s[WIDTH];

  // prev flop of the last stage is only carried for completeness of the step
  logic unused_prev;
  assign unused_prev = prev_s[WIDTH] ^ (|mcand_s[WIDTH]);

  `BR2M_ASSERT_ALWAYS(busy_never_a, !busy)
  `BR2M_ASSERT_IMPLY(done_follows_start_a, done_o, $past(start, Latency))
  `BR2M_ASSERT_IMPLY(zero_mcand_a, done_o && $past(multiplicand_i == '0, Latency),
                     product_o == '0)

endmodule

// ===== bench/tb_booth_radix2_multiplier.sv =====
// self-checking testbench for the radix-2 booth multiplier: directed rows, then random operands
// results are checked against typed products for known rows, else against a local booth add-and-shift predictor
// depends on br2m_pkg and booth_radix2_multiplier
`timescale 1ns / 1ps

module tb_booth_radix2_multiplier;
  import br2m_pkg::*;

  localparam int unsigned StepCount   = WidthDflt;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned CalmTail    = 150;
  localparam int unsigned MaxReported = 10;

  typedef logic signed [InBits-1:0]  operand_t;
  typedef logic signed [OutBits-1:0] product_t;

  typedef struct packed {
    operand_t mplier;
    operand_t mcand;
    logic     known;
    product_t product;
  } product_row_t;

  typedef struct packed {
    operand_t mplier;
    operand_t mcand;
    product_t product;
  } pending_product_t;

  logic     clk_i          = 1'b0;
  logic     rst_ni         = 1'b0;
  logic     start          = 1'b0;
  operand_t multiplier_i   = '0;
  operand_t multiplicand_i = '0;
  logic     row_known      = 1'b0;
  product_t row_product    = '0;
  logic     busy;
  logic     done_o;
  product_t product_o;

  pending_product_t pending_products[$];
  int unsigned      mismatches = 0;

  // typed products only where the answer is plain arithmetic
  product_row_t directed_rows [20] = '{
    '{5'sd0,    5'sd0,    1'b1, 9'sd0},
    '{5'sd15,   5'sd15,   1'b1, 9'sd225},
    '{5'sh10,   5'sd15,   1'b1, -9'sd240},
    '{5'sh10,   -5'sd15,  1'b1, 9'sd240},
    '{5'sd15,   -5'sd15,  1'b1, -9'sd225},
    '{5'sd1,    -5'sd1,   1'b1, -9'sd1},
    '{-5'sd1,   5'sd1,    1'b1, -9'sd1},
    '{-5'sd1,   -5'sd1,   1'b1, 9'sd1},
    '{5'sd1,    5'sd1,    1'b1, 9'sd1},
    '{5'sh10,   5'sd0,    1'b1, 9'sd0},
    '{5'sd0,    -5'sd15,  1'b1, 9'sd0},
    '{5'sh10,   5'sh10,   1'b0, 9'sd0},
    '{5'sd15,   5'sh10,   1'b0, 9'sd0},
    '{5'sd1,    5'sh10,   1'b0, 9'sd0},
    '{-5'sd1,   5'sh10,   1'b0, 9'sd0},
    '{5'sd10,   5'sd7,    1'b0, 9'sd0},
    '{-5'sd11,  -5'sd7,   1'b0, 9'sd0},
    '{5'sd6,    -5'sd5,   1'b0, 9'sd0},
    '{-5'sd8,   5'sd9,    1'b0, 9'sd0},
    '{5'sd3,    5'sd13,   1'b0, 9'sd0}
  };

  operand_t corner_values [6] = '{5'sh10, -5'sd15, -5'sd1, 5'sd0, 5'sd1, 5'sd15};

  booth_radix2_multiplier #(
    .WIDTH(StepCount)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .multiplier_i  (multiplier_i),
    .multiplicand_i(multiplicand_i),
    .done_o        (done_o),
    .product_o     (product_o)
  );

  always #10 clk_i = ~clk_i;

  // add-and-shift booth product, accumulator wraps at StepCount bits
  function automatic product_t booth_product(operand_t mplier, operand_t mcand);
    longint                 ext_q;
    longint                 ext_m;
    logic [StepCount-1:0]   acc;
    logic [StepCount-1:0]   q;
    logic [StepCount-1:0]   m;
    logic                   prev;
    booth_op_e              op;
    logic [63:0]            full;
    ext_q = longint'(mplier);
    ext_m = longint'(mcand);
    acc   = '0;
    q     = ext_q[StepCount-1:0];
    m     = ext_m[StepCount-1:0];
    prev  = 1'b0;
    for (int unsigned s = 0; s < StepCount; s++) begin
      op = booth_op_e'({q[0], prev});
      case (op)
        BoothSub: acc = acc - m;
        BoothAdd: acc = acc + m;
        default: ;
      endcase
      prev = q[0];
      q    = {acc[0], q[StepCount-1:1]};
      acc  = {acc[StepCount-1], acc[StepCount-1:1]};
    end
    full = 64'({acc, q});
    return full[OutBits-1:0];
  endfunction

  // record each accepted transfer, check each strobed product
  always @(posedge clk_i) begin
    pending_product_t entry;
    if (rst_ni) begin
      if (start && !busy) begin
        entry.mplier  = multiplier_i;
        entry.mcand   = multiplicand_i;
        entry.product = row_known ? row_product : booth_product(multiplier_i, multiplicand_i);
        pending_products.push_back(entry);
      end
      if (done_o) begin
        if (pending_products.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("unexpected product %0d with nothing pending", product_o);
          end
        end else begin
          entry = pending_products.pop_front();
          if (product_o !== entry.product) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
              $display("product mismatch for %0d * %0d: expected %0d, got %0d",
                       entry.mplier, entry.mcand, entry.product, product_o);
            end
          end
        end
      end
    end
  end

  task automatic transfer_operands(operand_t mplier, operand_t mcand, logic known,
                                   product_t product);
    start          <= 1'b1;
    multiplier_i   <= mplier;
    multiplicand_i <= mcand;
    row_known      <= known;
    row_product    <= product;
    do @(posedge clk_i); while (busy);
  endtask

  // operands keep changing while start is low, they must be ignored
  task automatic idle_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      multiplier_i   <= operand_t'($urandom);
      multiplicand_i <= operand_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    operand_t mplier;
    operand_t mcand;
    int       raw;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      transfer_operands(directed_rows[i].mplier, directed_rows[i].mcand,
                        directed_rows[i].known, directed_rows[i].product);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 16));
    end

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        mplier = corner_values[$urandom_range(0, 5)];
      end else begin
        mplier = operand_t'($urandom);
      end
      case ($urandom_range(0, 15))
        0: mcand = corner_values[$urandom_range(0, 5)];
        // full port range, the wrapping -16 case included
        1: mcand = operand_t'($urandom);
        default: begin
          raw   = int'($urandom_range(0, 30)) - 15;
          mcand = operand_t'(raw);
        end
      endcase
      transfer_operands(mplier, mcand, 1'b0, '0);
      if (n < RandomItems - CalmTail && $urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 16));
      end
    end

    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (2 * StepCount + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
